// ----- design/ssnf_pkg.sv -----
`timescale 1ns / 1ps

package ssnf_pkg;

  // display geometry
  localparam int DIGIT_POSITIONS = 4;
  localparam int OUT_POSITIONS   = 4;
  localparam int MAX_POSITIONS   = 8;
  localparam int POS_W           = $clog2(MAX_POSITIONS + 1);

  // field widths
  localparam int VALUE_W  = 32;
  localparam int RADIX_W  = 4;
  localparam int MASK_W   = 4;
  localparam int SEG_W    = 8;
  localparam int ACTION_W = 2;
  localparam int DIV_CNT_W = $clog2(VALUE_W);

  // radix limits
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_DEC   = RADIX_W'(10);

  // segment patterns, active low, bit 7 is the point
  localparam logic [SEG_W-1:0] SEG_BLANK      = 8'hFF;
  localparam logic [SEG_W-1:0] SEG_T          = 8'd135;
  localparam logic [SEG_W-1:0] SEG_POINT_KEEP = 8'h7F;

  localparam logic [SEG_W-1:0] GOOD_FRAME [OUT_POSITIONS] = '{8'd233, 8'd209, 8'd225, 8'd167};
  localparam logic [SEG_W-1:0] BAD_FRAME  [OUT_POSITIONS] = '{8'd233, 8'd189, 8'd241, 8'd0};

  typedef enum logic [ACTION_W-1:0] {
    ACT_NUMBER = 2'd0,
    ACT_TLABEL = 2'd1,
    ACT_GOOD   = 2'd2,
    ACT_BAD    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_FINISH
  } state_t;

  function automatic logic [SEG_W-1:0] glyph_of_digit(input logic [RADIX_W-1:0] d);
    logic [SEG_W-1:0] g;
    unique case (d)
      4'd0:    g = 8'd192;
      4'd1:    g = 8'd249;
      4'd2:    g = 8'd164;
      4'd3:    g = 8'd176;
      4'd4:    g = 8'd153;
      4'd5:    g = 8'd146;
      4'd6:    g = 8'd131;
      4'd7:    g = 8'd248;
      4'd8:    g = 8'd128;
      4'd9:    g = 8'd152;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

// ----- design/seven_segment_number_formatter.sv -----
`timescale 1ns / 1ps

// channel   | strobe / accept           | beat
// ----------+---------------------------+----------------------------------------
// request   | start && !busy            | action, value, point_mask
// frame     | done (one cycle)          | seg_pos0..seg_pos3, overflow
// config    | cfg_we                    | cfg_data -> number_base
//
// modes good and bad raise done the cycle after accept
// each digit of mode 0 or mode 1 is one full division on the shared bit-serial
// divider (a quotient bit per restoring step, then the hand-off), so a request
// needs one division per digit: up to four for mode 0, two for mode 1
// busy stays high from accept until the cycle after done
// synchronous reset returns to idle with number_base = 10
// the receiver cannot stall: every frame is shown for exactly one cycle

module seven_segment_number_formatter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ssnf_pkg::ACTION_W-1:0]     action,
  input  logic [ssnf_pkg::VALUE_W-1:0]      value,
  input  logic [ssnf_pkg::MASK_W-1:0]       point_mask,
  input  logic                              cfg_we,
  input  logic [ssnf_pkg::RADIX_W-1:0]      cfg_data,
  output logic                              done,
  output logic [ssnf_pkg::SEG_W-1:0]        seg_pos0,
  output logic [ssnf_pkg::SEG_W-1:0]        seg_pos1,
  output logic [ssnf_pkg::SEG_W-1:0]        seg_pos2,
  output logic [ssnf_pkg::SEG_W-1:0]        seg_pos3,
  output logic                              overflow
);
  import ssnf_pkg::*;

  state_t                 state;
  state_t                 state_next;

  logic [RADIX_W-1:0]     number_base;
  logic [RADIX_W-1:0]     radix;
  logic [RADIX_W-1:0]     radix_next;
  action_t                mode;
  logic [MASK_W-1:0]      mask;
  logic [POS_W-1:0]       pos;
  logic [POS_W-1:0]       pos_inc;
  logic [SEG_W-1:0]       frame [OUT_POSITIONS];
  logic                   ovf;

  logic                   accept;
  logic                   accept_div;
  logic                   more;
  logic                   div_start;
  logic [VALUE_W-1:0]     div_dividend;
  logic [VALUE_W-1:0]     div_quotient;
  logic [RADIX_W-1:0]     div_remainder;
  logic                   div_done;
  logic                   point_bit;
  logic [SEG_W-1:0]       digit_seg;

  assign accept     = start && !busy;
  // numbers and t-labels go through the divider, fixed patterns do not
  assign accept_div = accept && (action_t'(action) == ACT_NUMBER ||
                                 action_t'(action) == ACT_TLABEL);

  // radix is clamped into 2..10; the t-label always splits by ten
  always_comb begin
    if (action_t'(action) == ACT_TLABEL) begin
      radix_next = RADIX_DEC;
    end else if (number_base < RADIX_MIN) begin
      radix_next = RADIX_MIN;
    end else if (number_base > RADIX_MAX) begin
      radix_next = RADIX_MAX;
    end else begin
      radix_next = number_base;
    end
  end

  assign pos_inc = pos + POS_W'(1);

  // mode 0 stops on a zero quotient or a full display, mode 1 after two digits
  always_comb begin
    if (mode == ACT_NUMBER) begin
      more = (div_quotient != '0) && (pos_inc < POS_W'(DIGIT_POSITIONS));
    end else begin
      more = pos_inc < POS_W'(2);
    end
  end

  // point of the current position, only in mode 0
  always_comb begin
    point_bit = 1'b0;
    for (int i = 0; i < MASK_W; i++) begin
      if (pos == POS_W'(i)) begin
        point_bit = mask[i];
      end
    end
    if (mode != ACT_NUMBER) begin
      point_bit = 1'b0;
    end
  end

  always_comb begin
    digit_seg = glyph_of_digit(div_remainder);
    if (point_bit) begin
      digit_seg = digit_seg & SEG_POINT_KEEP;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_div) begin
          state_next = ST_WAIT;
        end else if (accept) begin
          state_next = ST_FINISH;
        end
      end
      ST_WAIT: begin
        if (div_done && !more) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy         = 1'b1;
    done         = 1'b0;
    div_start    = 1'b0;
    div_dividend = div_quotient;
    unique case (state)
      ST_IDLE: begin
        busy         = 1'b0;
        div_start    = accept_div;
        div_dividend = value;
      end
      ST_WAIT: begin
        div_start = div_done && more;
      end
      ST_FINISH: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      number_base <= RADIX_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        number_base <= cfg_data;
      end
    end
  end

  // per-request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode  <= action_t'(action);
      mask  <= point_mask;
      radix <= radix_next;
      pos   <= '0;
      ovf   <= 1'b0;
      for (int i = 0; i < OUT_POSITIONS; i++) begin
        unique case (action_t'(action))
          ACT_GOOD:   frame[i] <= GOOD_FRAME[i];
          ACT_BAD:    frame[i] <= BAD_FRAME[i];
          ACT_TLABEL: frame[i] <= (i == OUT_POSITIONS - 1) ? SEG_T : SEG_BLANK;
          default:    frame[i] <= SEG_BLANK;
        endcase
      end
    end else if (state == ST_WAIT && div_done) begin
      for (int i = 0; i < OUT_POSITIONS; i++) begin
        if (pos == POS_W'(i)) begin
          frame[i] <= digit_seg;
        end
      end
      pos <= pos_inc;
      // digits left over once the display is full
      ovf <= (mode == ACT_NUMBER) && !more && (div_quotient != '0);
    end
  end

  ssnf_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (accept ? radix_next : radix),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .done      (div_done)
  );

  // positions past the configured digit count stay blank
  assign seg_pos0 = (0 < DIGIT_POSITIONS) ? frame[0] : SEG_BLANK;
  assign seg_pos1 = (1 < DIGIT_POSITIONS) ? frame[1] : SEG_BLANK;
  assign seg_pos2 = (2 < DIGIT_POSITIONS) ? frame[2] : SEG_BLANK;
  assign seg_pos3 = (3 < DIGIT_POSITIONS) ? frame[3] : SEG_BLANK;
  assign overflow = ovf;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_WAIT))
    else $error("divider finished outside the wait state");

  a_div_start_ctx: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == ST_IDLE || (state == ST_WAIT && div_done)))
    else $error("divider started while still running");
`endif

endmodule

// ----- design/ssnf_divider.sv -----
`timescale 1ns / 1ps

module ssnf_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ssnf_pkg::VALUE_W-1:0]   dividend,
  input  logic [ssnf_pkg::RADIX_W-1:0]   divisor,
  output logic [ssnf_pkg::VALUE_W-1:0]   quotient,
  output logic [ssnf_pkg::RADIX_W-1:0]   remainder,
  output logic                           done
);
  import ssnf_pkg::*;

  logic                   run;
  logic [DIV_CNT_W-1:0]   cnt;
  logic [RADIX_W-1:0]     div;
  logic [RADIX_W:0]       rem_sh;
  logic [RADIX_W:0]       diff;
  logic                   fits;

  // one restoring step per cycle, remainder stays below the divisor
  assign rem_sh = {remainder, quotient[VALUE_W-1]};
  assign diff   = rem_sh - {1'b0, div};
  assign fits   = rem_sh >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(VALUE_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      div       <= divisor;
    end else if (run) begin
      quotient  <= {quotient[VALUE_W-2:0], fits};
      remainder <= fits ? diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
    end
  end

endmodule
